>>> hw/rtl/cpsf_pkg.sv
// Shared types, command codes and helpers for the convex polygon scanline fill block.
package cpsf_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_SPAN  = 2'd2;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
  } vertex_t;

  typedef struct packed {
    logic       touched;
    logic [9:0] left;
    logic [9:0] right;
  } row_entry_t;

  function automatic logic [9:0] sat10(input logic signed [11:0] v);
    logic [9:0] r;
    if (v < 0) begin
      r = 10'd0;
    end else if (v > 12'sd1023) begin
      r = 10'd1023;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/convex_polygon_scanline_fill_top.sv
// Top level: vertex intake, slope divider and row edge table for convex polygon fill.
// Span read: result strobe and busy in the cycle after the accepting edge; busy then drops
//   again for the next accept.
// Add vertex / close: an edge runs the slope divider (S_DIV), then one cycle per spanned
//   row (S_WALK). A horizontal edge or no edge returns straight to idle.
// One row per cycle is set by the edge table RAM read-modify-write pipeline.
// After rst the table is swept clear row by row with busy high; results are never stalled.
module convex_polygon_scanline_fill_top #(
  parameter int ROWS      = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [9:0] vertex_x,
  input  logic [9:0] vertex_y,
  output logic       result_valid,
  output logic [9:0] span_row,
  output logic [9:0] span_left,
  output logic [9:0] span_right,
  output logic       span_nonempty
);

  localparam int RW = $clog2(ROWS);
  localparam int DW = FRAC_BITS + 10;
  localparam int XW = FRAC_BITS + 12;
  localparam int CW = $clog2(DW);
  localparam logic [12:0] ROWS_L = 13'(ROWS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_WALK  = 5'b01000,
    S_SPAN  = 5'b10000
  } state_t;

  state_t state;

  cpsf_pkg::vertex_t first_v, prev_v, in_v, ea, eb;
  logic [1:0]  vcount;
  logic [RW-1:0] clr_addr;

  logic [9:0]  lo_x, hi_y, walk_y, dy;
  logic        neg;
  logic [DW-1:0] dvd;
  logic [10:0] rem;
  logic [CW-1:0] div_cnt;
  logic signed [XW-1:0] x_acc, slope;

  logic          p_v;
  logic [RW-1:0] p_addr;
  logic [9:0]    p_cl, p_fl;

  logic       span_ok;
  logic [RW-1:0] span_addr;

  logic accept, has_edge, y_in_rows, walk_in_rows;
  logic [9:0] absdx, trial_sub;
  logic [10:0] trial;
  logic qbit;
  logic signed [XW-1:0] x_ceil;
  logic [12:0] in_y_ext, walk_y_ext;

  logic          we;
  logic [RW-1:0] waddr, raddr;
  cpsf_pkg::row_entry_t wdata, rdata;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE) || p_v;

  assign in_v.x = vertex_x;
  assign in_v.y = vertex_y;
  assign ea = prev_v;
  assign eb = (cmd == cpsf_pkg::CMD_ADD) ? in_v : first_v;
  assign has_edge = (cmd == cpsf_pkg::CMD_ADD || cmd == cpsf_pkg::CMD_CLOSE) &&
                    (vcount != 2'd0) && (ea.y != eb.y);

  assign in_y_ext   = {3'b000, vertex_y};
  assign walk_y_ext = {3'b000, walk_y};
  assign y_in_rows    = in_y_ext < ROWS_L;
  assign walk_in_rows = walk_y_ext < ROWS_L;

  assign trial     = {rem[9:0], dvd[DW-1]};
  assign qbit      = trial >= {1'b0, dy};
  assign trial_sub = 10'(trial - {1'b0, dy});

  assign x_ceil = x_acc + XW'((64'd1 << FRAC_BITS) - 64'd1);

  always_comb begin
    we    = 1'b0;
    waddr = p_addr;
    wdata = '0;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (p_v) begin
      we            = 1'b1;
      wdata.touched = 1'b1;
      wdata.left    = (!rdata.touched || p_cl < rdata.left) ? p_cl : rdata.left;
      wdata.right   = (!rdata.touched || p_fl > rdata.right) ? p_fl : rdata.right;
    end else if (state == S_SPAN && span_ok) begin
      we    = 1'b1;
      waddr = span_addr;
      wdata = '{touched: 1'b0, left: rdata.left, right: rdata.right};
    end
  end

  assign raddr = (state == S_WALK) ? walk_y_ext[RW-1:0] : in_y_ext[RW-1:0];

  cpsf_ram #(
    .WIDTH($bits(cpsf_pkg::row_entry_t)),
    .DEPTH(ROWS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (eb.x >= ea.x) begin
      absdx = (ea.y < eb.y) ? 10'(eb.x - ea.x) : 10'(eb.x - ea.x);
    end else begin
      absdx = 10'(ea.x - eb.x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      vcount   <= 2'd0;
      first_v  <= '0;
      prev_v   <= '0;
      p_v      <= 1'b0;
    end else begin
      p_v <= (state == S_WALK) && (walk_y != hi_y) && walk_in_rows;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == RW'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            // edge and span setup
            span_ok   <= y_in_rows;
            span_addr <= in_y_ext[RW-1:0];
            span_row  <= vertex_y;
            rem       <= '0;
            div_cnt   <= CW'(DW - 1);
            if (ea.y < eb.y) begin
              lo_x   <= ea.x;
              walk_y <= ea.y;
              hi_y   <= eb.y;
              dy     <= 10'(eb.y - ea.y);
              neg    <= eb.x < ea.x;
              dvd    <= {absdx, {FRAC_BITS{1'b0}}} + DW'(10'(eb.y - ea.y) >> 1);
            end else begin
              lo_x   <= eb.x;
              walk_y <= eb.y;
              hi_y   <= ea.y;
              dy     <= 10'(ea.y - eb.y);
              neg    <= ea.x < eb.x;
              dvd    <= {absdx, {FRAC_BITS{1'b0}}} + DW'(10'(ea.y - eb.y) >> 1);
            end
            case (cmd)
              cpsf_pkg::CMD_ADD: begin
                if (vcount == 2'd0) begin
                  first_v <= in_v;
                end
                prev_v <= in_v;
                if (vcount != 2'd2) begin
                  vcount <= vcount + 2'd1;
                end
              end
              cpsf_pkg::CMD_CLOSE: begin
                vcount <= 2'd0;
              end
              cpsf_pkg::CMD_SPAN: begin
                state <= S_SPAN;
              end
              default: begin
              end
            endcase
            if (has_edge) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dvd     <= {dvd[DW-2:0], qbit};
          rem     <= qbit ? {1'b0, trial_sub} : trial;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            state <= S_WALK;
            slope <= neg ? -XW'({dvd[DW-2:0], qbit}) : XW'({dvd[DW-2:0], qbit});
            x_acc <= $signed({2'b00, lo_x, {FRAC_BITS{1'b0}}});
          end
        end
        S_WALK: begin
          if (walk_y != hi_y) begin
            p_addr <= walk_y_ext[RW-1:0];
            p_cl   <= cpsf_pkg::sat10(x_ceil[XW-1:FRAC_BITS]);
            p_fl   <= cpsf_pkg::sat10(x_acc[XW-1:FRAC_BITS]);
            x_acc  <= x_acc + slope;
            walk_y <= walk_y + 10'd1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SPAN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid  = (state == S_SPAN);
  assign span_left     = (span_ok && rdata.touched) ? rdata.left : 10'd0;
  assign span_right    = (span_ok && rdata.touched) ? rdata.right : 10'd0;
  assign span_nonempty = span_ok && rdata.touched && (rdata.left <= rdata.right);

endmodule

>>> hw/rtl/cpsf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cpsf_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the convex polygon scanline fill block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int FRAC = 16;
  localparam int TABLE_ROWS = 1024;
  localparam int ITEM_TARGET = 570;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] left;
    logic [9:0] right;
    logic       nonempty;
  } span_t;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] x;
    logic [9:0] y;
    logic       typed;
    logic [9:0] left;
    logic [9:0] right;
    logic       nonempty;
  } step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] cmd = CMD_NOP;
  logic [9:0] vertex_x = '0;
  logic [9:0] vertex_y = '0;
  logic       busy;
  logic       result_valid;
  logic [9:0] span_row;
  logic [9:0] span_left;
  logic [9:0] span_right;
  logic       span_nonempty;

  convex_polygon_scanline_fill_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .result_valid (result_valid),
    .span_row     (span_row),
    .span_left    (span_left),
    .span_right   (span_right),
    .span_nonempty(span_nonempty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // edge table model
  logic [9:0]        tbl_left[TABLE_ROWS];
  logic [9:0]        tbl_right[TABLE_ROWS];
  bit                tbl_touched[TABLE_ROWS];
  cpsf_pkg::vertex_t poly_first;
  cpsf_pkg::vertex_t poly_prev;
  int                poly_vertices;

  span_t span_expect_q[$];
  int    bad_count = 0;
  int    stall_cycles = 0;
  int    sent = 0;
  bit    gaps_on = 1'b1;
  bit    pin_on = 1'b0;
  span_t pin_span;

  function automatic logic [9:0] clamp_col(input longint v);
    if (v < 0) return 10'd0;
    if (v > 1023) return 10'd1023;
    return v[9:0];
  endfunction

  task automatic walk_edge(input cpsf_pkg::vertex_t a, input cpsf_pkg::vertex_t b);
    cpsf_pkg::vertex_t lo, hi;
    longint     dx, dy, num, slope, xf;
    int         r;
    logic [9:0] cl, fl;
    if (a.y == b.y) return;
    if (a.y < b.y) begin
      lo = a;
      hi = b;
    end else begin
      lo = b;
      hi = a;
    end
    dx = longint'(hi.x) - longint'(lo.x);
    dy = longint'(hi.y) - longint'(lo.y);
    num = dx * (longint'(1) << FRAC);
    if (num >= 0) slope = (num + dy / 2) / dy;
    else slope = -((-num + dy / 2) / dy);
    xf = longint'(lo.x) << FRAC;
    for (r = int'(lo.y); r < int'(hi.y); r++) begin
      if (r < TABLE_ROWS) begin
        cl = clamp_col(-((-xf) >>> FRAC));
        fl = clamp_col(xf >>> FRAC);
        if (!tbl_touched[r]) begin
          tbl_touched[r] = 1'b1;
          tbl_left[r] = cl;
          tbl_right[r] = fl;
        end else begin
          if (cl < tbl_left[r]) tbl_left[r] = cl;
          if (fl > tbl_right[r]) tbl_right[r] = fl;
        end
      end
      xf += slope;
    end
  endtask

  task automatic apply_command(input logic [1:0] op, input logic [9:0] x, input logic [9:0] y,
                               output bit has_span, output span_t res);
    cpsf_pkg::vertex_t v;
    v.x = x;
    v.y = y;
    has_span = 1'b0;
    res = '0;
    case (op)
      cpsf_pkg::CMD_ADD: begin
        if (poly_vertices == 0) poly_first = v;
        else walk_edge(poly_prev, v);
        poly_prev = v;
        if (poly_vertices < 2) poly_vertices++;
      end
      cpsf_pkg::CMD_CLOSE: begin
        if (poly_vertices != 0) walk_edge(poly_prev, poly_first);
        poly_vertices = 0;
      end
      cpsf_pkg::CMD_SPAN: begin
        has_span = 1'b1;
        res.row = y;
        if (int'(y) < TABLE_ROWS && tbl_touched[y]) begin
          res.left = tbl_left[y];
          res.right = tbl_right[y];
          res.nonempty = (tbl_left[y] <= tbl_right[y]);
          tbl_touched[y] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    foreach (tbl_touched[i]) tbl_touched[i] = 1'b0;
    poly_first = '0;
    poly_prev = '0;
    poly_vertices = 0;
  end

  // result checking and prediction on accepted transactions
  always @(posedge clk) begin
    bit    got_span;
    span_t pred;
    span_t want;
    if (!rst) begin
      if (result_valid) begin
        if (span_expect_q.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected span result: row=%0d left=%0d right=%0d ne=%0d",
                     span_row, span_left, span_right, span_nonempty);
          bad_count++;
        end else begin
          want = span_expect_q.pop_front();
          if (span_row !== want.row || span_left !== want.left ||
              span_right !== want.right || span_nonempty !== want.nonempty) begin
            if (bad_count < 10)
              $display("span mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       want.row, want.left, want.right, want.nonempty,
                       span_row, span_left, span_right, span_nonempty);
            bad_count++;
          end
        end
      end
      if (start && !busy) begin
        apply_command(cmd, vertex_x, vertex_y, got_span, pred);
        if (got_span) begin
          if (pin_on) begin
            pred.left = pin_span.left;
            pred.right = pin_span.right;
            pred.nonempty = pin_span.nonempty;
          end
          span_expect_q.insert(span_expect_q.size(), pred);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue(input step_t s);
    sent++;
    gaps_on = !(sent >= 250 && sent < 350);
    while (gaps_on && $urandom_range(99, 0) < 13) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= s.op;
    vertex_x <= s.x;
    vertex_y <= s.y;
    pin_on = s.typed;
    pin_span.left = s.left;
    pin_span.right = s.right;
    pin_span.nonempty = s.nonempty;
    do @(posedge clk); while (busy);
    @(negedge clk);
    pin_on = 1'b0;
  endtask

  function automatic step_t mk(input logic [1:0] op, input logic [9:0] x, input logic [9:0] y);
    step_t s;
    s = '0;
    s.op = op;
    s.x = x;
    s.y = y;
    return s;
  endfunction

  step_t plan[$];

  function automatic void add_step(input step_t s);
    plan.insert(plan.size(), s);
  endfunction

  initial begin
    step_t s;
    int    n, h, w, base_x, base_y, ylo, yhi, reads;
    bit    wide;
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd0, 1'b1, 10'd0, 10'd0, 1'b0});
    add_step('{cpsf_pkg::CMD_SPAN, 10'd1023, 10'd1023, 1'b1, 10'd0, 10'd0, 1'b0});
    add_step(mk(cpsf_pkg::CMD_CLOSE, 10'd0, 10'd0));
    add_step(mk(CMD_NOP, 10'd1023, 10'd1023));
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd0, 10'd0));
    add_step(mk(cpsf_pkg::CMD_CLOSE, 10'd1023, 10'd1023));
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd0, 1'b1, 10'd0, 10'd0, 1'b0});
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd0, 10'd0));
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd1023, 10'd1023));
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd0, 10'd1023));
    add_step(mk(cpsf_pkg::CMD_CLOSE, 10'd0, 10'd0));
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd1023, 1'b1, 10'd0, 10'd0, 1'b0});
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd500, 1'b1, 10'd0, 10'd500, 1'b1});
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd0, 1'b1, 10'd0, 10'd0, 1'b1});
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd0, 1'b1, 10'd0, 10'd0, 1'b0});
    add_step('{cpsf_pkg::CMD_SPAN, 10'd0, 10'd1022, 1'b1, 10'd0, 10'd1022, 1'b1});
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd10, 10'd0));
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd11, 10'd3));
    add_step(mk(cpsf_pkg::CMD_CLOSE, 10'd0, 10'd0));
    add_step(mk(cpsf_pkg::CMD_SPAN, 10'd0, 10'd1));
    add_step('{cpsf_pkg::CMD_SPAN, 10'd1023, 10'd0, 1'b1, 10'd10, 10'd10, 1'b1});
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd1023, 10'd0));
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd0, 10'd5));
    add_step(mk(cpsf_pkg::CMD_ADD, 10'd1023, 10'd5));
    add_step(mk(cpsf_pkg::CMD_CLOSE, 10'd0, 10'd0));
    add_step(mk(cpsf_pkg::CMD_SPAN, 10'd682, 10'd2));
    add_step(mk(cpsf_pkg::CMD_SPAN, 10'd0, 10'd4));

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) issue(plan[i]);

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(99, 0) < 80) begin
        wide = ($urandom_range(99, 0) < 8);
        h = wide ? 1023 : $urandom_range(40, 1);
        w = wide ? 1023 : $urandom_range(80, 1);
        base_y = $urandom_range(1023 - h, 0);
        base_x = $urandom_range(1023 - w, 0);
        n = $urandom_range(6, 1);
        ylo = 1023;
        yhi = 0;
        for (int k = 0; k < n; k++) begin
          s = mk(cpsf_pkg::CMD_ADD, 10'(base_x + $urandom_range(w, 0)),
                 10'(base_y + $urandom_range(h, 0)));
          if (int'(s.y) < ylo) ylo = int'(s.y);
          if (int'(s.y) > yhi) yhi = int'(s.y);
          issue(s);
        end
        if ($urandom_range(99, 0) < 90)
          issue(mk(cpsf_pkg::CMD_CLOSE, 10'($urandom), 10'($urandom)));
        reads = $urandom_range(6, 1);
        for (int k = 0; k < reads; k++)
          issue(mk(cpsf_pkg::CMD_SPAN, 10'($urandom), 10'($urandom_range(yhi, ylo))));
      end else begin
        issue(mk(2'($urandom_range(3, 0)), 10'($urandom), 10'($urandom)));
      end
    end
    start <= 1'b0;

    while (span_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && span_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cpsf_pkg.sv
hw/rtl/cpsf_ram.sv
hw/rtl/convex_polygon_scanline_fill_top.sv
tb/testbench.sv
